@@ src/fisr_pkg.sv @@
package fisr_pkg;

	// Set geometry
	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ID_W     = 32;
	localparam int COUNT_W  = 7;
	localparam int COUNT_MAX = 127;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int NUM_RANGES = 3;

	localparam logic [CFG_IDX_W-1:0] REG_A_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_A_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B_LOW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B_HIGH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_C_LOW  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_C_HIGH = 3'd5;

	// Operation codes
	localparam logic [1:0] KIND_QUERY   = 2'd0;
	localparam logic [1:0] KIND_ENABLE  = 2'd1;
	localparam logic [1:0] KIND_DISABLE = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic               supported;
		logic               status;
		logic [COUNT_W-1:0] set_count;
	} result_t;

	// Clamp the held count to the output field
	function automatic logic [COUNT_W-1:0] sat_count(input logic [CNT_W-1:0] cnt);
		if (32'(cnt) > 32'(COUNT_MAX)) begin
			sat_count = COUNT_W'(COUNT_MAX);
		end else begin
			sat_count = COUNT_W'(cnt);
		end
	endfunction

endpackage

@@ src/fisr_ram.sv @@
module fisr_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ src/fisr_cfg.sv @@
module fisr_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fisr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fisr_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [fisr_pkg::ID_W-1:0]        id,
	output logic                             in_range
);
	import fisr_pkg::*;

	logic [ID_W-1:0] low_q  [NUM_RANGES];
	logic [ID_W-1:0] high_q [NUM_RANGES];
	logic [NUM_RANGES-1:0] hit;
	logic in_range_q;

	// Range registers; reset leaves every range empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_RANGES; r++) begin
				low_q[r]  <= ID_W'(1);
				high_q[r] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_A_LOW:  low_q[0]  <= cfg_data;
				REG_A_HIGH: high_q[0] <= cfg_data;
				REG_B_LOW:  low_q[1]  <= cfg_data;
				REG_B_HIGH: high_q[1] <= cfg_data;
				REG_C_LOW:  low_q[2]  <= cfg_data;
				REG_C_HIGH: high_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Inclusive bounds; low above high matches nothing
	always_comb begin
		for (int r = 0; r < NUM_RANGES; r++) begin
			hit[r] = (low_q[r] <= id) && (id <= high_q[r]);
		end
	end

	// Registered; id is held steady for the whole scan
	always_ff @(posedge clk) begin
		in_range_q <= |hit;
	end

	assign in_range = in_range_q;

endmodule

@@ src/fisr_scan.sv @@
module fisr_scan (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  kind,
	input  logic [fisr_pkg::ID_W-1:0]   ident,
	output logic [fisr_pkg::ID_W-1:0]   id_held,
	input  logic                        in_range,
	output logic                        res_valid,
	input  logic                        res_ready,
	output fisr_pkg::result_t           res
);
	import fisr_pkg::*;

	state_t state_q, state_d;

	logic [1:0]      kind_q;
	logic [ID_W-1:0] id_q;

	// Scan address and compare stage
	logic [CNT_W-1:0] rd_cnt_q;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic [ID_W-1:0]  rd_data;
	logic             cmp_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             valid_s1;
	logic             scan_done;

	// Scan findings
	logic             hit_q, free_q;
	logic [IDX_W-1:0] hit_idx_q, free_idx_q;

	logic [CAPACITY-1:0] valid_q;
	logic [CNT_W-1:0]    held_q;

	// Update decisions
	logic             do_insert, do_remove, set_full;
	logic [CNT_W-1:0] held_d;
	logic             apply;
	logic             wr_en;

	assign rd_addr   = rd_cnt_q[IDX_W-1:0];
	assign scan_done = (rd_cnt_q == CNT_W'(CAPACITY)) && !cmp_s1;
	assign id_held   = id_q;

	assign do_insert = (kind_q == KIND_ENABLE) && !hit_q && free_q;
	assign set_full  = (kind_q == KIND_ENABLE) && !hit_q && !free_q;
	assign do_remove = (kind_q == KIND_DISABLE) && hit_q;

	always_comb begin
		held_d = held_q;
		if (do_insert) begin
			held_d = held_q + CNT_W'(1);
		end else if (do_remove) begin
			held_d = held_q - CNT_W'(1);
		end
	end

	fisr_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (ID_W)
	) u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (free_idx_q),
		.wr_data (id_q)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_done) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (res_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready  = 1'b0;
		rd_en     = 1'b0;
		res_valid = 1'b0;
		apply     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_SCAN: begin
				rd_en = (rd_cnt_q != CNT_W'(CAPACITY));
			end
			ST_UPDATE: begin
				res_valid = 1'b1;
				apply     = res_ready;
			end
			default: ;
		endcase
	end

	assign wr_en = apply && do_insert;

	assign res.supported = (hit_q && !do_remove) || do_insert || in_range;
	assign res.status    = set_full;
	assign res.set_count = sat_count(held_d);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_cnt_q <= '0;
			cmp_s1   <= 1'b0;
			hit_q    <= 1'b0;
			free_q   <= 1'b0;
			valid_q  <= '0;
			held_q   <= '0;
		end else begin
			state_q <= state_d;
			cmp_s1  <= rd_en;
			if (in_ready && in_valid) begin
				rd_cnt_q <= '0;
				hit_q    <= 1'b0;
				free_q   <= 1'b0;
			end
			if (rd_en) begin
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
			end
			// first matching slot and lowest free slot
			if (cmp_s1) begin
				if (valid_s1 && (rd_data == id_q) && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (!valid_s1 && !free_q) begin
					free_q <= 1'b1;
				end
			end
			if (apply) begin
				held_q <= held_d;
				if (do_insert) valid_q[free_idx_q] <= 1'b1;
				if (do_remove) valid_q[hit_idx_q]  <= 1'b0;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_q <= kind;
			id_q   <= ident;
		end
		idx_s1   <= rd_addr;
		valid_s1 <= valid_q[rd_addr];
		if (cmp_s1) begin
			if (valid_s1 && (rd_data == id_q) && !hit_q) hit_idx_q <= idx_s1;
			if (!valid_s1 && !free_q) free_idx_q <= idx_s1;
		end
	end

endmodule

@@ src/feature_id_set_with_ranges.sv @@
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid, in_stall | kind, ident
// out     | output    | out_valid, out_stall | supported, status, set_count
// cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// Each item is answered after a scan of the whole set: the
// identifier memory is read one entry per cycle over its single read port.
// Reset empties the set and the ranges at once; no clearing pass is needed.
// A result waits in the output register while the next item is scanned;
// the scan only holds at its update step if that register is still full.
module feature_id_set_with_ranges (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      kind,
	input  logic [fisr_pkg::ID_W-1:0]       ident,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            supported,
	output logic                            status,
	output logic [fisr_pkg::COUNT_W-1:0]    set_count,
	input  logic                            cfg_we,
	input  logic [fisr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fisr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fisr_pkg::*;

	logic            in_ready;
	logic [ID_W-1:0] id_held;
	logic            in_range;
	logic            res_valid, res_ready;
	result_t         res;
	result_t         out_q;
	logic            out_valid_q;

	fisr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.id        (id_held),
		.in_range  (in_range)
	);

	fisr_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.ident      (ident),
		.id_held    (id_held),
		.in_range   (in_range),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	assign in_stall  = !in_ready;
	assign res_ready = !out_valid_q || !out_stall;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign supported = out_q.supported;
	assign status    = out_q.status;
	assign set_count = out_q.set_count;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import fisr_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 7;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DIR_N        = 25;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 100;
	localparam int POOL_N       = 80;
	localparam int TAIL_CYCLES  = CAPACITY + 8;
	localparam int PRINT_CAP    = 200;

	// Codes the package leaves unnamed
	localparam logic [1:0]           KIND_SPARE   = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef enum int {MIX_OPS, FILL_SET, EMPTY_SET} phase_style_t;

	typedef struct packed {
		logic [1:0]      op;
		logic [ID_W-1:0] id;
		logic [1:0]      stage;
		logic            typed;
		result_t         want;
	} dir_row_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  in_valid   = 1'b0;
	logic                  in_stall;
	logic [1:0]            kind       = KIND_QUERY;
	logic [ID_W-1:0]       ident      = '0;
	logic                  out_valid;
	logic                  out_stall  = 1'b0;
	logic                  supported;
	logic                  status;
	logic [COUNT_W-1:0]    set_count;
	logic                  cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = REG_A_LOW;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;

	feature_id_set_with_ranges uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.ident       (ident),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.supported   (supported),
		.status      (status),
		.set_count   (set_count),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Shadow of the set and the ranges
	logic [ID_W-1:0] held_ids  [CAPACITY];
	bit              held_used [CAPACITY];
	int              held_total;
	logic [ID_W-1:0] span_lo [NUM_RANGES];
	logic [ID_W-1:0] span_hi [NUM_RANGES];

	result_t         awaited_membership [$];
	int              mismatches = 0;
	bit              sink_stalls = 1'b0;
	int              stall_left = 0;

	dir_row_t        dir_rows [DIR_N];
	logic [ID_W-1:0] stage_lo [4][NUM_RANGES];
	logic [ID_W-1:0] stage_hi [4][NUM_RANGES];
	logic [ID_W-1:0] next_lo [NUM_RANGES];
	logic [ID_W-1:0] next_hi [NUM_RANGES];
	logic [ID_W-1:0] id_pool [POOL_N];

	// Membership after one operation; updates the shadow set
	function automatic result_t predict_membership(input logic [1:0] op,
			input logic [ID_W-1:0] id);
		result_t r;
		int      hit;
		int      free_slot;
		bit      present;
		bit      in_span;
		hit       = -1;
		free_slot = -1;
		in_span   = 1'b0;
		r.status  = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (held_used[i]) begin
				if (hit < 0 && held_ids[i] == id)
					hit = i;
			end else if (free_slot < 0) begin
				free_slot = i;
			end
		end
		present = (hit >= 0);
		if (op == KIND_ENABLE && !present) begin
			if (free_slot >= 0) begin
				held_ids[free_slot]  = id;
				held_used[free_slot] = 1'b1;
				held_total++;
				present = 1'b1;
			end else begin
				r.status = 1'b1;
			end
		end else if (op == KIND_DISABLE && present) begin
			held_used[hit] = 1'b0;
			held_total--;
			present = 1'b0;
		end
		for (int g = 0; g < NUM_RANGES; g++)
			if (span_lo[g] <= id && id <= span_hi[g])
				in_span = 1'b1;
		r.supported = present || in_span;
		r.set_count = (held_total > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(held_total);
		return r;
	endfunction

	function automatic dir_row_t make_row(input logic [1:0] op, input logic [ID_W-1:0] id,
			input logic [1:0] stage, input logic typed, input logic sup, input logic st,
			input logic [COUNT_W-1:0] cnt);
		dir_row_t d;
		d.op                 = op;
		d.id                 = id;
		d.stage              = stage;
		d.typed              = typed;
		d.want.supported     = sup;
		d.want.status        = st;
		d.want.set_count     = cnt;
		return d;
	endfunction

	// Identifier for a random beat: mostly the pool, some range edges, some noise
	function automatic logic [ID_W-1:0] pick_id();
		int sel;
		int g;
		sel = $urandom_range(0, 99);
		g   = $urandom_range(0, NUM_RANGES - 1);
		if (sel < 72)
			return id_pool[$urandom_range(0, POOL_N - 1)];
		if (sel < 88) begin
			case ($urandom_range(0, 3))
				0:       return span_lo[g] - 1;
				1:       return span_lo[g];
				2:       return span_hi[g];
				default: return span_hi[g] + 1;
			endcase
		end
		return $urandom;
	endfunction

	task automatic pick_range(output logic [ID_W-1:0] lo, output logic [ID_W-1:0] hi);
		logic [ID_W-1:0] a;
		logic [ID_W-1:0] b;
		logic [ID_W-1:0] centre;
		a      = $urandom;
		b      = $urandom;
		centre = id_pool[$urandom_range(0, POOL_N - 1)];
		case ($urandom_range(0, 7))
			0: begin
				// low above high: empty
				lo = (a > b) ? a : b;
				hi = (a > b) ? b : a;
				if (lo == hi) begin
					lo = 1;
					hi = 0;
				end
			end
			1: begin
				lo = centre;
				hi = centre;
			end
			2, 6: begin
				lo = centre - $urandom_range(0, 8);
				hi = centre + $urandom_range(0, 8);
			end
			3: begin
				lo = '0;
				hi = '1;
			end
			4: begin
				lo = '0;
				hi = $urandom_range(0, 16);
			end
			5: begin
				lo = '1 - $urandom_range(0, 16);
				hi = '1;
			end
			default: begin
				lo = (a > b) ? b : a;
				hi = (a > b) ? a : b;
			end
		endcase
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ID_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_A_LOW:  span_lo[0] = val;
			REG_A_HIGH: span_hi[0] = val;
			REG_B_LOW:  span_lo[1] = val;
			REG_B_HIGH: span_hi[1] = val;
			REG_C_LOW:  span_lo[2] = val;
			REG_C_HIGH: span_hi[2] = val;
			default: ;
		endcase
	endtask

	task automatic program_ranges();
		write_reg(REG_A_LOW,  next_lo[0]);
		write_reg(REG_A_HIGH, next_hi[0]);
		write_reg(REG_B_LOW,  next_lo[1]);
		write_reg(REG_B_HIGH, next_hi[1]);
		write_reg(REG_C_LOW,  next_lo[2]);
		write_reg(REG_C_HIGH, next_hi[2]);
	endtask

	// One input beat; the expectation is queued once the block takes it
	task automatic issue_op(input logic [1:0] op, input logic [ID_W-1:0] id,
			input logic typed, input result_t want);
		result_t r;
		in_valid <= 1'b1;
		kind     <= op;
		ident    <= id;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		r = predict_membership(op, id);
		awaited_membership = {awaited_membership, (typed ? want : r)};
	endtask

	task automatic sender_gap(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (awaited_membership.size() != 0);
	endtask

	task automatic flag_mismatch(input string what, input logic [ID_W-1:0] got,
			input logic [ID_W-1:0] want);
		if (mismatches < PRINT_CAP)
			$display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Output side stalls in bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 7);
			out_stall  <= 1'b1;
		end else begin
			out_stall  <= 1'b0;
		end
	end

	// Result beats against the oldest expectation
	always @(posedge clk) begin : take_result
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_membership.size() == 0) begin
				flag_mismatch("result with nothing awaited", ID_W'(set_count), '0);
			end else begin
				want = awaited_membership.pop_front();
				if (supported !== want.supported)
					flag_mismatch("supported", ID_W'(supported), ID_W'(want.supported));
				if (status !== want.status)
					flag_mismatch("status", ID_W'(status), ID_W'(want.status));
				if (set_count !== want.set_count)
					flag_mismatch("set_count", ID_W'(set_count), ID_W'(want.set_count));
			end
		end
	end

	initial begin : watchdog
		for (int cyc = 0; cyc < CYCLE_LIMIT; cyc++)
			@(posedge clk);
		$display("** feature_id_set_with_ranges: FAILED **");
		$finish;
	end

	initial begin : stimulus
		phase_style_t    style;
		logic [1:0]      cur_stage;
		logic [1:0]      op;
		logic [ID_W-1:0] id;
		int              cursor;
		int              sel;
		bit              sender_idles;
		result_t         none;

		none       = '0;
		cursor     = 0;
		held_total = 0;
		for (int i = 0; i < CAPACITY; i++) begin
			held_ids[i]  = '0;
			held_used[i] = 1'b0;
		end
		for (int g = 0; g < NUM_RANGES; g++) begin
			span_lo[g] = 1;
			span_hi[g] = 0;
		end

		// Identifier pool, extremes first
		id_pool[0] = '0;
		id_pool[1] = '1;
		id_pool[2] = 32'h8000_0000;
		id_pool[3] = 32'h7FFF_FFFF;
		for (int i = 4; i < POOL_N; i++)
			id_pool[i] = $urandom;

		// Directed ranges: stage 0 keeps the reset values
		stage_lo[1] = '{32'h0, 32'hFFFF_FFFF, 32'h1000};
		stage_hi[1] = '{32'h0, 32'hFFFF_FFFF, 32'h1FFF};
		stage_lo[2] = '{32'h0, 32'h5, 32'hFFFF_FFFF};
		stage_hi[2] = '{32'hFFFF_FFFF, 32'h4, 32'h0};
		stage_lo[3] = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h1};
		stage_hi[3] = '{32'h0, 32'h7FFF_FFFF, 32'h0};

		// Empty set, empty ranges
		dir_rows[0]  = make_row(KIND_QUERY,   32'h0,         0, 1, 0, 0, 0);
		dir_rows[1]  = make_row(KIND_QUERY,   32'hFFFF_FFFF, 0, 1, 0, 0, 0);
		dir_rows[2]  = make_row(KIND_ENABLE,  32'hFFFF_FFFF, 0, 1, 1, 0, 1);
		// insert of a held identifier
		dir_rows[3]  = make_row(KIND_ENABLE,  32'hFFFF_FFFF, 0, 1, 1, 0, 1);
		// remove of an absent identifier
		dir_rows[4]  = make_row(KIND_DISABLE, 32'h0,         0, 1, 0, 0, 1);
		// unused kind behaves as a query
		dir_rows[5]  = make_row(KIND_SPARE,   32'hFFFF_FFFF, 0, 1, 1, 0, 1);
		dir_rows[6]  = make_row(KIND_ENABLE,  32'h0,         0, 1, 1, 0, 2);
		dir_rows[7]  = make_row(KIND_DISABLE, 32'hFFFF_FFFF, 0, 1, 0, 0, 1);
		dir_rows[8]  = make_row(KIND_ENABLE,  32'h1,         0, 1, 1, 0, 2);
		dir_rows[9]  = make_row(KIND_QUERY,   32'h1,         0, 1, 1, 0, 2);
		dir_rows[10] = make_row(KIND_SPARE,   32'h5,         0, 1, 0, 0, 2);
		dir_rows[11] = make_row(KIND_DISABLE, 32'h0,         0, 1, 0, 0, 1);
		// Point ranges at both ends and a window
		dir_rows[12] = make_row(KIND_QUERY,   32'h0,         1, 1, 1, 0, 1);
		dir_rows[13] = make_row(KIND_QUERY,   32'hFFFF_FFFF, 1, 1, 1, 0, 1);
		dir_rows[14] = make_row(KIND_QUERY,   32'h0FFF,      1, 0, 0, 0, 0);
		dir_rows[15] = make_row(KIND_QUERY,   32'h1000,      1, 0, 0, 0, 0);
		dir_rows[16] = make_row(KIND_QUERY,   32'h1FFF,      1, 0, 0, 0, 0);
		dir_rows[17] = make_row(KIND_QUERY,   32'h2000,      1, 0, 0, 0, 0);
		dir_rows[18] = make_row(KIND_DISABLE, 32'h0,         1, 0, 0, 0, 0);
		dir_rows[19] = make_row(KIND_ENABLE,  32'h1800,      1, 0, 0, 0, 0);
		dir_rows[20] = make_row(KIND_DISABLE, 32'h1800,      1, 0, 0, 0, 0);
		// Full span, the other two empty
		dir_rows[21] = make_row(KIND_QUERY,   32'h1234_5678, 2, 1, 1, 0, 1);
		dir_rows[22] = make_row(KIND_DISABLE, 32'h1,         2, 1, 1, 0, 0);
		// All empty, spare register writes must not land anywhere
		dir_rows[23] = make_row(KIND_QUERY,   32'h8000_0000, 3, 0, 0, 0, 0);
		dir_rows[24] = make_row(KIND_SPARE,   32'h0,         3, 0, 0, 0, 0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		cur_stage = 0;
		for (int r = 0; r < DIR_N; r++) begin
			if (dir_rows[r].stage != cur_stage) begin
				cur_stage = dir_rows[r].stage;
				wait_for_results();
				next_lo = stage_lo[cur_stage];
				next_hi = stage_hi[cur_stage];
				program_ranges();
				if (cur_stage == 3) begin
					write_reg(REG_SPARE_LO, '0);
					write_reg(REG_SPARE_HI, '1);
				end
				cfg_we <= 1'b0;
			end
			issue_op(dir_rows[r].op, dir_rows[r].id, dir_rows[r].typed, dir_rows[r].want);
		end

		// Random phases: fill to full, drain, mixed; idling off in the last ones
		for (int p = 0; p < PHASES; p++) begin
			style        = (p == 0 || p == 2 || p == 5) ? FILL_SET :
			               (p == 3 || p == 6) ? EMPTY_SET : MIX_OPS;
			sender_idles = !(p == 4 || p >= PHASES - 2);
			sink_stalls  = !(p == 1 || p >= PHASES - 2);

			wait_for_results();
			for (int g = 0; g < NUM_RANGES; g++)
				pick_range(next_lo[g], next_hi[g]);
			program_ranges();
			if ($urandom_range(0, 2) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
			cfg_we <= 1'b0;

			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ((p == 2 && i == PHASE_ITEMS / 2) ||
						(p < PHASES - 2 && $urandom_range(0, 149) == 0))
					wait_for_results();
				else if (sender_idles && $urandom_range(0, 3) == 0)
					sender_gap($urandom_range(1, 8));

				sel = $urandom_range(0, 99);
				case (style)
					FILL_SET:  op = (sel < 85) ? KIND_ENABLE : 2'($urandom_range(0, 3));
					EMPTY_SET: op = (sel < 80) ? KIND_DISABLE : 2'($urandom_range(0, 3));
					default:   op = 2'($urandom_range(0, 3));
				endcase
				if (style != MIX_OPS && $urandom_range(0, 99) < 70) begin
					id     = id_pool[cursor];
					cursor = (cursor + 1) % POOL_N;
				end else begin
					id = pick_id();
				end
				issue_op(op, id, 1'b0, none);
			end
		end

		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("** feature_id_set_with_ranges: PASSED **");
		else
			$display("** feature_id_set_with_ranges: FAILED **");
		$finish;
	end

endmodule

@@ files.f @@
src/fisr_pkg.sv
src/fisr_ram.sv
src/fisr_cfg.sv
src/fisr_scan.sv
src/feature_id_set_with_ranges.sv
bench/tb_top.sv
